@@ hdl/ecvs_pkg.sv @@
package ecvs_pkg;

  // Default number of cache entries tracked by the victim selector.
  localparam int CACHE_ENTRIES = 16;

  // Width of the entry field of a request and of the reported victim.
  localparam int ENTRY_W = 4;

  // Width of the exclusion mask; entries at or above it are never excluded.
  localparam int MASK_W = 16;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ACCESS      = 2'd0,
    OP_INSTALL     = 2'd1,
    OP_CLEAR_DIRTY = 2'd2,
    OP_FIND_VICTIM = 2'd3
  } op_t;

  // Sweep rounds of a victim search, in the order they are tried.
  typedef enum logic [1:0] {
    RND_FREE       = 2'd0,
    RND_DIRTY_AGE  = 2'd1,
    RND_CLEAN      = 2'd2,
    RND_DIRTY      = 2'd3
  } round_t;

  // One request.
  typedef struct packed {
    op_t                 operation;
    logic [ENTRY_W-1:0]  entry;
    logic                mark_dirty;
    logic                occupied;
    logic                used;
    logic [MASK_W-1:0]   exclude_mask;
  } req_t;

  // One result of a victim search.
  typedef struct packed {
    logic [ENTRY_W-1:0]  victim_entry;
    logic                found;
    logic                victim_dirty;
    logic                victim_empty;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;    // capture the exclusion mask of a victim search
    logic    update;   // apply a flag update request
    logic    sweep;    // evaluate one sweep round this cycle
    round_t  round;    // which round is evaluated
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    hit;      // the current round found a victim
  } dp_status_t;

endpackage

@@ hdl/ecvs_ctrl.sv @@
module ecvs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  ecvs_pkg::op_t          operation,
  input  ecvs_pkg::dp_status_t   status,
  output ecvs_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    ROUND0 = 5'b00010,
    ROUND1 = 5'b00100,
    ROUND2 = 5'b01000,
    ROUND3 = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  // Command decode for the datapath.
  always_comb begin
    cmd        = '0;
    cmd.latch  = accept && (operation == ecvs_pkg::OP_FIND_VICTIM);
    cmd.update = accept && (operation != ecvs_pkg::OP_FIND_VICTIM);
    cmd.round  = ecvs_pkg::RND_FREE;
    unique case (state)
      IDLE: begin
        cmd.sweep = 1'b0;
      end
      ROUND0: begin
        cmd.sweep = 1'b1;
        cmd.round = ecvs_pkg::RND_FREE;
      end
      ROUND1: begin
        cmd.sweep = 1'b1;
        cmd.round = ecvs_pkg::RND_DIRTY_AGE;
      end
      ROUND2: begin
        cmd.sweep = 1'b1;
        cmd.round = ecvs_pkg::RND_CLEAN;
      end
      ROUND3: begin
        cmd.sweep = 1'b1;
        cmd.round = ecvs_pkg::RND_DIRTY;
      end
      default: begin
        cmd.sweep = 1'b0;
      end
    endcase
  end

  // A search steps through the rounds until one hits or the last is done.
  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:    if (cmd.latch) state_next = ROUND0;
      ROUND0:  state_next = status.hit ? IDLE : ROUND1;
      ROUND1:  state_next = status.hit ? IDLE : ROUND2;
      ROUND2:  state_next = status.hit ? IDLE : ROUND3;
      ROUND3:  state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted search always begins with the first round.
  assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.sweep && (cmd.round == ecvs_pkg::RND_FREE))
    else $error("search did not start with the first round");

  // A round that hits ends the search.
  assert property (@(posedge clk) disable iff (rst)
    cmd.sweep && status.hit |=> state == IDLE)
    else $error("search continued after a hit");

endmodule

@@ hdl/ecvs_dp.sv @@
module ecvs_dp #(
  parameter int CACHE_ENTRIES = ecvs_pkg::CACHE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ecvs_pkg::req_t         request,
  input  ecvs_pkg::dp_cmd_t      cmd,
  output ecvs_pkg::dp_status_t   status,
  output logic                   done,
  output ecvs_pkg::rsp_t         result
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int N     = CACHE_ENTRIES;

  // Per-entry flags and the clock hand.
  logic [N-1:0]     occ;
  logic [N-1:0]     used;
  logic [N-1:0]     dirty;
  logic [N-1:0]     occ_next;
  logic [N-1:0]     used_next;
  logic [N-1:0]     dirty_next;
  logic [IDX_W-1:0] hand;
  logic [IDX_W-1:0] hand_next;

  // Search operands and outputs.
  logic [N-1:0]     excl;
  logic [N-1:0]     excl_next;
  logic [N-1:0]     cand;
  logic [N-1:0]     ge_start;
  logic [N-1:0]     visited;
  logic [IDX_W-1:0] low_hi;
  logic [IDX_W-1:0] low_all;
  logic [IDX_W-1:0] vic;
  logic [IDX_W-1:0] rep;
  logic [IDX_W+ecvs_pkg::ENTRY_W-1:0] rep_wide;
  logic             hit;
  logic             finish;
  logic             done_next;
  ecvs_pkg::rsp_t   result_next;

  // Request entry index and its range check.
  logic [IDX_W-1:0] ent_idx;
  logic             ent_ok;

  assign ent_idx = IDX_W'(request.entry);
  assign ent_ok  = {28'd0, request.entry} < 32'(N);

  // The exclusion mask covers only the first entries that it has bits for.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      excl_next[i] = (i < ecvs_pkg::MASK_W) ? request.exclude_mask[i % ecvs_pkg::MASK_W]
                                            : 1'b0;
    end
  end

  // Candidate vector of the round under evaluation.
  always_comb begin
    case (cmd.round)
      ecvs_pkg::RND_FREE:      cand = (~occ | (~dirty & ~used)) & ~excl;
      ecvs_pkg::RND_DIRTY_AGE: cand = occ & dirty & ~used & ~excl;
      ecvs_pkg::RND_CLEAN:     cand = occ & ~dirty & ~used & ~excl;
      default:                 cand = occ & dirty & ~used & ~excl;
    endcase
  end

  // Rotated priority encoder: first candidate at or after the hand, wrapping.
  always_comb begin
    low_hi  = '0;
    low_all = '0;
    for (int i = 0; i < N; i++) begin
      ge_start[i] = IDX_W'(i) >= hand;
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (cand[i] && ge_start[i]) low_hi = IDX_W'(i);
      if (cand[i]) low_all = IDX_W'(i);
    end
  end

  assign hit = |cand;
  assign vic = (|(cand & ge_start)) ? low_hi : low_all;

  // Entries passed over by the sweep, from the hand up to the victim, or all entries on no hit.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!hit) begin
        visited[i] = 1'b1;
      end else if (vic >= hand) begin
        visited[i] = ge_start[i] && (IDX_W'(i) <= vic);
      end else begin
        visited[i] = ge_start[i] || (IDX_W'(i) <= vic);
      end
    end
  end

  assign status.hit = hit;
  assign finish     = cmd.sweep && (hit || (cmd.round == ecvs_pkg::RND_DIRTY));
  assign done_next  = finish;

  // Flag updates from requests and from the used-bit aging round.
  always_comb begin
    occ_next   = occ;
    used_next  = used;
    dirty_next = dirty;
    if (cmd.update && ent_ok) begin
      unique case (request.operation)
        ecvs_pkg::OP_ACCESS: begin
          used_next[ent_idx]  = 1'b1;
          dirty_next[ent_idx] = dirty[ent_idx] | request.mark_dirty;
        end
        ecvs_pkg::OP_INSTALL: begin
          occ_next[ent_idx]   = request.occupied;
          used_next[ent_idx]  = request.used;
          dirty_next[ent_idx] = request.mark_dirty;
        end
        ecvs_pkg::OP_CLEAR_DIRTY: begin
          dirty_next[ent_idx] = 1'b0;
        end
        default: begin
          occ_next = occ;
        end
      endcase
    end
    if (cmd.sweep && (cmd.round == ecvs_pkg::RND_DIRTY_AGE)) begin
      used_next = used & ~(visited & occ);
    end
  end

  // Result and hand: the hand moves one past the victim, or past the start.
  assign rep      = hit ? vic : hand;
  assign rep_wide = {{ecvs_pkg::ENTRY_W{1'b0}}, rep};

  always_comb begin
    hand_next = hand;
    if (finish) begin
      hand_next = (rep == IDX_W'(N - 1)) ? '0 : rep + 1'b1;
    end
    result_next.victim_entry = rep_wide[ecvs_pkg::ENTRY_W-1:0];
    result_next.found        = hit;
    result_next.victim_dirty = hit && occ[vic] && dirty[vic];
    result_next.victim_empty = hit && !occ[vic];
  end

  // Control and flag state.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      used  <= '0;
      dirty <= '0;
      hand  <= '0;
      done  <= 1'b0;
    end else begin
      occ   <= occ_next;
      used  <= used_next;
      dirty <= dirty_next;
      hand  <= hand_next;
      done  <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      excl <= excl_next;
    end
    if (finish) begin
      result <= result_next;
    end
  end

  // A result only follows a sweep round.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.sweep))
    else $error("result strobe without a sweep round");

  // A failed search reports no victim flags.
  assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> !result.victim_dirty && !result.victim_empty)
    else $error("victim flags set on a failed search");

endmodule

@@ hdl/enhanced_clock_victim_select.sv @@
// Channel | Signals                     | Direction | Handshake
// --------+-----------------------------+-----------+---------------------------
// request | start, busy, request        | in        | taken when start && !busy
// result  | done, result                | out       | valid for one cycle on done
//
// Flag update requests (access, install, clear dirty) keep busy low.
// A find-victim request keeps busy high for one to four sweep rounds, each round a
// rotated priority encoder over the flag vectors; done follows in the next cycle.
// A new request may be taken in the cycle that done is shown.
// Synchronous reset clears all flags to empty, unused and clean and the hand to zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
module enhanced_clock_victim_select #(
  parameter int CACHE_ENTRIES = ecvs_pkg::CACHE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ecvs_pkg::req_t  request,
  output logic            done,
  output ecvs_pkg::rsp_t  result
);

  ecvs_pkg::dp_cmd_t    cmd;
  ecvs_pkg::dp_status_t status;

  // Sequencer of the sweep rounds.
  ecvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Flag store, clock hand and round evaluation.
  ecvs_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule
